// ----- sv/ztun_pkg.sv -----
// ----------------------------------------------------------------------------
// Zero-crossing pitch tuner package
// Shared widths, codes and the control structs that pass between the
// sequencer and the estimate ring.
// ----------------------------------------------------------------------------
package ztun_pkg;

   // Field widths fixed by the interface.
   localparam int SAMPLE_W = 12;
   localparam int FREQ_W   = 20;
   localparam int CSR_IDX_W = 2;

   // Special frequency values.
   localparam logic [FREQ_W-1:0] NO_ENTRY  = 20'hFFFFF;
   localparam logic [FREQ_W-1:0] ENTRY_MAX = 20'hFFFFE;

   // Reset level of the zero line.
   localparam logic [SAMPLE_W-1:0] MIDPOINT_RESET = 12'd2048;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MIDPOINT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 2'd2;

   // Held tuning indication.
   typedef enum logic [1:0] {
      TUNE_NONE = 2'd0,
      TUNE_HIGH = 2'd1,
      TUNE_LOW  = 2'd2,
      TUNE_IN   = 2'd3
   } tune_type;

   // Command from the sequencer to the ring: store one estimate and rescan.
   typedef struct packed {
      logic              write;
      logic [FREQ_W-1:0] value;
   } ring_cmd_type;

   // Status from the ring: scan finished, with the smallest non-zero entry.
   typedef struct packed {
      logic              done;
      logic [FREQ_W-1:0] minimum;
   } ring_stat_type;

endpackage

// ----- sv/ztun_divider.sv -----
// ----------------------------------------------------------------------------
// Constant-dividend restoring divider
// Divides the fixed DIVIDEND by a run-time divisor, one quotient bit per
// cycle. The quotient stays on its output until the next start.
// ----------------------------------------------------------------------------
module ztun_divider import ztun_pkg::*; #(
   parameter int DIVIDEND  = 40000,
   parameter int DIVISOR_W = 33,
   parameter int QUO_W     = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output logic [QUO_W-1:0]     quotient
);

   localparam int CMP_W = (QUO_W + 1 > DIVISOR_W) ? QUO_W + 1 : DIVISOR_W;
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [QUO_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [QUO_W:0]       rem_shift;
   logic [CMP_W-1:0]     trial;
   logic                 fits;

   // One restoring step: bring in the next dividend bit and try a subtract.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[QUO_W-1]};
      trial     = CMP_W'(rem_shift) - CMP_W'(dvs_ff);
      fits      = CMP_W'(rem_shift) >= CMP_W'(dvs_ff);
   end

   // Step control.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUO_W);
         rem_in  = '0;
         quo_in  = QUO_W'(DIVIDEND);
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial[QUO_W-1:0] : rem_shift[QUO_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- sv/ztun_ring.sv -----
// ----------------------------------------------------------------------------
// Estimate ring with minimum scan
// Stores estimates round-robin and, after each store, walks every entry
// through one read port to find the smallest non-zero value.
// ----------------------------------------------------------------------------
module ztun_ring import ztun_pkg::*; #(
   parameter int RING_DEPTH = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  ring_cmd_type  cmd,
   output ring_stat_type stat
);

   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   logic [FREQ_W-1:0]     mem [RING_DEPTH];
   logic [RING_DEPTH-1:0] valid_ff;
   logic [IDX_W-1:0]      ptr_ff;
   logic [IDX_W-1:0]      issue_ff;
   logic                  scanning_ff;
   logic                  cmp_en_ff;
   logic                  cmp_last_ff;
   logic                  rd_valid_ff;
   logic [FREQ_W-1:0]     rd_data_ff;
   logic [FREQ_W-1:0]     best_ff;
   logic [FREQ_W-1:0]     best_in;
   logic                  take;

   // Entry storage: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[ptr_ff] <= cmd.value;
      end
      rd_data_ff <= mem[issue_ff];
   end

   // Compare stage: an entry never written or holding zero is skipped.
   always_comb begin
      take    = rd_valid_ff && (rd_data_ff != '0) && (rd_data_ff <= best_ff);
      best_in = take ? rd_data_ff : best_ff;
   end

   // Write pointer, valid bits and scan sequencing.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         ptr_ff      <= '0;
         issue_ff    <= '0;
         scanning_ff <= 1'b0;
         cmp_en_ff   <= 1'b0;
         cmp_last_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
         best_ff     <= NO_ENTRY;
      end else begin
         rd_valid_ff <= valid_ff[issue_ff];
         cmp_en_ff   <= scanning_ff;
         cmp_last_ff <= scanning_ff && (issue_ff == IDX_W'(RING_DEPTH - 1));
         if (cmp_en_ff) begin
            best_ff <= best_in;
         end
         if (cmd.write) begin
            valid_ff[ptr_ff] <= 1'b1;
            ptr_ff           <= (ptr_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : ptr_ff + IDX_W'(1);
            issue_ff         <= '0;
            scanning_ff      <= 1'b1;
            best_ff          <= NO_ENTRY;
         end else if (scanning_ff) begin
            if (issue_ff == IDX_W'(RING_DEPTH - 1)) begin
               scanning_ff <= 1'b0;
               issue_ff    <= '0;
            end else begin
               issue_ff <= issue_ff + IDX_W'(1);
            end
         end
      end
   end

   assign stat.done    = cmp_en_ff && cmp_last_ff;
   assign stat.minimum = best_in;

endmodule

// ----- sv/zero_crossing_pitch_tuner.sv -----
// ----------------------------------------------------------------------------
// Zero-crossing pitch tuner
// Detects midpoint crossings of an ADC sample stream, turns the distance
// between the last rising and falling crossings into a frequency estimate,
// keeps the smallest recent estimate and judges it against a target.
// ----------------------------------------------------------------------------
// One word in gives one word out. A sample that makes no usable crossing
// goes from the gap state straight to the judge state. A sample that stores
// a new estimate passes through the divide, write and scan states: the
// divider produces one quotient bit per cycle for each of the quotient bits
// of SAMPLE_RATE (16 at 40000), and the ring is then scanned one entry per
// cycle through its single read port. Input is taken only in the idle
// state; a finished result waits in the output register while the next
// sample is accepted. Output detected_freq is zero before the first
// estimate and all ones when no ring entry is non-zero.
// ----------------------------------------------------------------------------
module zero_crossing_pitch_tuner import ztun_pkg::*; #(
   parameter int RING_DEPTH  = 8,
   parameter int SAMPLE_RATE = 40000,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   // Sample input: tdata[11:0] sample.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,
   // Result output: tdata[19:0] detected_freq, [21:20] tune_state,
   // [22] estimate_updated, [23] zero.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,
   // Configuration writes.
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FREQ_W-1:0]    csr_wdata
);

   localparam int QUO_W   = $clog2(SAMPLE_RATE + 1);
   localparam int DVS_W   = COUNT_WIDTH + 1;
   localparam int SCALE_W = (QUO_W + 4 > FREQ_W + 1) ? QUO_W + 4 : FREQ_W + 1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_GAP   = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_WRITE = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_JUDGE = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [SAMPLE_W-1:0]    midpoint_ff;
   logic [FREQ_W-1:0]      reference_ff;
   logic [FREQ_W-1:0]      tolerance_ff;
   logic [SAMPLE_W-1:0]    prev_ff, prev_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] rise_ff, rise_in;
   logic [COUNT_WIDTH-1:0] fall_ff, fall_in;
   logic                   cross_ff, cross_in;
   logic                   upd_ff, upd_in;
   logic [FREQ_W-1:0]      cur_ff, cur_in;
   logic [FREQ_W-1:0]      prior_ff, prior_in;
   tune_type               ind_ff, ind_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FREQ_W-1:0]      rsp_freq_ff, rsp_freq_in;
   tune_type               rsp_tune_ff, rsp_tune_in;
   logic                   rsp_upd_ff, rsp_upd_in;

   logic [SAMPLE_W-1:0]    sample;
   logic                   accept;
   logic                   rising;
   logic                   falling;
   logic [COUNT_WIDTH-1:0] gap;
   logic                   div_start;
   logic                   div_done;
   logic [QUO_W-1:0]       quotient;
   logic [SCALE_W-1:0]     scaled;
   logic [FREQ_W-1:0]      entry;
   logic [FREQ_W:0]        upper;
   logic [FREQ_W-1:0]      lower;
   tune_type               verdict;
   logic                   out_free;
   ring_cmd_type           ring_cmd;
   ring_stat_type          ring_stat;

   // Divider: SAMPLE_RATE / (2 * gap).
   ztun_divider #(
      .DIVIDEND  (SAMPLE_RATE),
      .DIVISOR_W (DVS_W),
      .QUO_W     (QUO_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  ({gap, 1'b0}),
      .done     (div_done),
      .quotient (quotient)
   );

   // Estimate ring and its minimum scan.
   ztun_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (ring_cmd),
      .stat  (ring_stat)
   );

   // Crossing detection against the midpoint level.
   always_comb begin
      sample  = req_tdata[SAMPLE_W-1:0];
      accept  = req_tvalid && req_tready;
      rising  = (sample >= midpoint_ff) && (prev_ff < midpoint_ff);
      falling = (sample < midpoint_ff) && (prev_ff > midpoint_ff);
      gap     = (fall_ff > rise_ff) ? fall_ff - rise_ff : rise_ff - fall_ff;
   end

   // Scale the quotient by 16 and keep it clear of the no-entry marker.
   always_comb begin
      scaled = SCALE_W'(quotient) << 4;
      entry  = (scaled > SCALE_W'(ENTRY_MAX)) ? ENTRY_MAX : scaled[FREQ_W-1:0];
   end

   // Compare the estimate with the target window; the lower edge stops at zero.
   always_comb begin
      upper = {1'b0, reference_ff} + {1'b0, tolerance_ff};
      lower = (reference_ff > tolerance_ff) ? reference_ff - tolerance_ff : '0;
      if ({1'b0, cur_ff} > upper) begin
         verdict = TUNE_HIGH;
      end else if (cur_ff < lower) begin
         verdict = TUNE_LOW;
      end else begin
         verdict = TUNE_IN;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      prev_in        = prev_ff;
      count_in       = count_ff;
      rise_in        = rise_ff;
      fall_in        = fall_ff;
      cross_in       = cross_ff;
      upd_in         = upd_ff;
      cur_in         = cur_ff;
      prior_in       = prior_ff;
      ind_in         = ind_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_freq_in    = rsp_freq_ff;
      rsp_tune_in    = rsp_tune_ff;
      rsp_upd_in     = rsp_upd_ff;
      div_start      = 1'b0;
      ring_cmd.write = 1'b0;
      ring_cmd.value = entry;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               prev_in  = sample;
               count_in = count_ff + COUNT_WIDTH'(1);
               cross_in = rising || falling;
               if (rising) begin
                  rise_in = count_ff;
               end
               if (falling) begin
                  fall_in = count_ff;
               end
               state_in = ST_GAP;
            end
         end
         ST_GAP: begin
            upd_in = cross_ff && (gap != '0);
            if (cross_ff && (gap != '0)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_JUDGE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ring_cmd.write = 1'b1;
            prior_in       = cur_ff;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (ring_stat.done) begin
               cur_in   = ring_stat.minimum;
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            if (cur_ff != prior_ff) begin
               ind_in = verdict;
            end
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_freq_in  = cur_ff;
               rsp_tune_in  = (cur_ff != prior_ff) ? verdict : ind_ff;
               rsp_upd_in   = upd_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and tracking state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         midpoint_ff  <= MIDPOINT_RESET;
         reference_ff <= '0;
         tolerance_ff <= '0;
         prev_ff      <= '0;
         count_ff     <= '0;
         rise_ff      <= '0;
         fall_ff      <= '0;
         cross_ff     <= 1'b0;
         upd_ff       <= 1'b0;
         cur_ff       <= '0;
         prior_ff     <= '0;
         ind_ff       <= TUNE_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         rise_ff      <= rise_in;
         fall_ff      <= fall_in;
         cross_ff     <= cross_in;
         upd_ff       <= upd_in;
         cur_ff       <= cur_in;
         prior_ff     <= prior_in;
         ind_ff       <= ind_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MIDPOINT:  midpoint_ff  <= csr_wdata[SAMPLE_W-1:0];
               CSR_REFERENCE: reference_ff <= csr_wdata;
               CSR_TOLERANCE: tolerance_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Output word register.
   always_ff @(posedge clock) begin
      rsp_freq_ff <= rsp_freq_in;
      rsp_tune_ff <= rsp_tune_in;
      rsp_upd_ff  <= rsp_upd_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_upd_ff, rsp_tune_ff, rsp_freq_ff};

endmodule

// ----- sv/ztun_checker.sv -----
// ----------------------------------------------------------------------------
// Zero-crossing pitch tuner port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module ztun_checker import ztun_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // No result word is shown right after reset.
   a_reset_clears_out: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result word holds its value.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // Input ready drops once a sample is taken, as the sequencer leaves the idle state.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a sample was taken");

   // With no estimate yet there is no indication.
   a_no_estimate_no_tune: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[19:0] == 20'd0) |-> rsp_tdata[21:20] == TUNE_NONE)
      else $error("indication given without an estimate");

   // A fresh estimate always leaves a non-zero detected frequency.
   a_update_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[22] |-> rsp_tdata[19:0] != 20'd0)
      else $error("update reported with zero frequency");

endmodule

bind zero_crossing_pitch_tuner ztun_checker u_ztun_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
